// ----- design/assert_macros.svh -----
// Assertion macros used by the encoder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never hold at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// Whenever the premise holds, the consequence must hold in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

// ----- design/a85_pkg.sv -----
// Shared types and constants of the Ascii85 encoder.
package a85_pkg;

   localparam int unsigned CHAR_W      = 7;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned HELD_W      = 24;
   localparam int unsigned GROUP_W     = 32;
   localparam int unsigned NDIG_W      = 3;
   localparam int unsigned COUNT_W     = 2;
   localparam logic [NDIG_W-1:0] DIGITS_FULL = 3'd5;

   localparam logic [CHAR_W-1:0] CHAR_LT      = 7'h3C;
   localparam logic [CHAR_W-1:0] CHAR_TILDE   = 7'h7E;
   localparam logic [CHAR_W-1:0] CHAR_GT      = 7'h3E;
   localparam logic [CHAR_W-1:0] CHAR_Z       = 7'h7A;
   localparam logic [CHAR_W-1:0] DIGIT_OFFSET = 7'd33;

   // A group is scaled to a binary fraction of 85^5 with FRAC_W fraction bits.
   // Multiplying that fraction by 85 yields the base-85 digits most significant
   // first; the rounding error stays below one unit of the last digit.
   localparam int unsigned FRAC_W  = 65;
   localparam int unsigned RECIP_W = 33;
   localparam logic [67:0] POW85_5    = 68'd4437053125;
   localparam logic [67:0] RECIP_WIDE = ((68'd1 << FRAC_W) + POW85_5 - 68'd1) / POW85_5;
   localparam logic [RECIP_W-1:0] RECIP_85_5 = RECIP_WIDE[RECIP_W-1:0];

   localparam int unsigned Q_DEPTH = 2;
   localparam int unsigned Q_PTR_W = 1;
   localparam int unsigned Q_CNT_W = 2;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_ZERO,
      KIND_DIGITS
   } job_kind_type;

   typedef struct packed {
      logic                open_req;
      job_kind_type        kind;
      logic [GROUP_W-1:0]  group;
      logic [NDIG_W-1:0]   ndig;
      logic                close_req;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OPEN1,
      ST_OPEN2,
      ST_ZERO,
      ST_DIGIT,
      ST_CLOSE1,
      ST_CLOSE2
   } back_state_type;

endpackage

// ----- design/ascii85_encoder_unit.sv -----
// Ascii85 stream encoder: one byte in per input beat, one character out per output beat.
//
// The req_ channel carries one byte per beat (req_byte_value, qualified by req_has_byte)
// and req_end_of_data, which closes the stream after that beat. The rsp_ channel
// returns one ASCII character per beat; rsp_last_char marks the last character that
// an input beat produced. A beat that opens a stream first yields '<~', every fourth
// byte yields five base-85 digits (or 'z' for an all-zero group), and the closing
// beat flushes a partial group as count+1 digits followed by '~>'.
// The front end gathers bytes and takes a beat every cycle while its two-entry job
// queue has room. The back end pops one job per idle cycle and then emits one
// character per cycle while the receiver takes them: a full group is scaled by the
// reciprocal multiply as its job is popped and then yields its five digits in turn,
// so the sustained input rate is set by the single-character result channel.
// A beat's first character passes the job queue, back-end state and output register.
// Reset (synchronous, active high) empties the queue, drops any gathered bytes and
// marks no stream open. When the receiver stalls, the output register holds its
// character, the back end waits, and once the queue fills req_ready falls.
`include "assert_macros.svh"

module ascii85_encoder_unit import a85_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_byte_value,
   input  logic              req_has_byte,
   input  logic              req_end_of_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CHAR_W-1:0] rsp_out_char,
   output logic              rsp_last_char
);

   // Jobs travel from the front end to the back end through a short queue.
   logic    q_push;
   logic    q_pop;
   logic    q_empty;
   logic    q_full;
   job_type push_job;
   job_type pop_job;

   a85_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_byte_value  (req_byte_value),
      .req_has_byte    (req_has_byte),
      .req_end_of_data (req_end_of_data),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_job           (push_job)
   );

   a85_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .empty    (q_empty),
      .full     (q_full)
   );

   // The back end owns the output register, so the receiver never stalls the front end
   // directly.
   a85_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_job         (pop_job),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

   // The queue is never written while full nor read while empty.
   `ASSERT_NEVER(a_push_full, clock, reset, q_push && q_full, "job pushed into a full queue")
   `ASSERT_NEVER(a_pop_empty, clock, reset, q_pop && q_empty, "job popped from an empty queue")
   // Every emitted character is printable Ascii85 text.
   `ASSERT_IMPLIES(a_char_range, clock, reset, rsp_valid,
      (rsp_out_char >= 7'd33) && (rsp_out_char <= 7'd126), "character out of range")
   // The input side is held off whenever the job queue is full.
   `ASSERT_NEVER(a_ready_full, clock, reset, req_ready && q_full, "input ready with a full queue")

endmodule

// ----- design/a85_front.sv -----
// Front end: accepts input beats, gathers groups and issues output jobs.
module a85_front import a85_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_byte_value,
   input  logic              req_has_byte,
   input  logic              req_end_of_data,
   input  logic              q_full,
   output logic              q_push,
   output job_type           q_job
);

   logic [HELD_W-1:0]  held_bytes_ff, held_bytes_in;
   logic [COUNT_W-1:0] held_count_ff, held_count_in;
   logic               stream_open_ff, stream_open_in;
   logic               accept;
   logic [GROUP_W-1:0] full_group;
   logic [HELD_W-1:0]  held_after;
   logic [COUNT_W-1:0] count_after;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      q_job.open_req  = !stream_open_ff;
      q_job.kind      = KIND_NONE;
      q_job.group     = '0;
      q_job.ndig      = '0;
      q_job.close_req = req_end_of_data;
      held_after      = held_bytes_ff;
      count_after     = held_count_ff;
      full_group      = {held_bytes_ff, req_byte_value};

      if (req_has_byte) begin
         if (held_count_ff == 2'd3) begin
            q_job.kind  = (full_group == '0) ? KIND_ZERO : KIND_DIGITS;
            q_job.group = full_group;
            q_job.ndig  = DIGITS_FULL;
            held_after  = '0;
            count_after = '0;
         end else begin
            held_after  = {held_bytes_ff[15:0], req_byte_value};
            count_after = held_count_ff + 2'd1;
         end
      end

      // A partial group is zero padded on the right and never becomes 'z'.
      if (req_end_of_data && (count_after != '0)) begin
         q_job.kind = KIND_DIGITS;
         q_job.ndig = {1'b0, count_after} + 3'd1;
         case (count_after)
            2'd1:    q_job.group = {held_after[7:0], 24'h0};
            2'd2:    q_job.group = {held_after[15:0], 16'h0};
            default: q_job.group = {held_after, 8'h0};
         endcase
      end

      if (req_end_of_data) begin
         held_bytes_in  = '0;
         held_count_in  = '0;
         stream_open_in = 1'b0;
      end else begin
         held_bytes_in  = held_after;
         held_count_in  = count_after;
         stream_open_in = 1'b1;
      end

      q_push = accept && (q_job.open_req || (q_job.kind != KIND_NONE) || req_end_of_data);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_bytes_ff  <= '0;
         held_count_ff  <= '0;
         stream_open_ff <= 1'b0;
      end else if (accept) begin
         held_bytes_ff  <= held_bytes_in;
         held_count_ff  <= held_count_in;
         stream_open_ff <= stream_open_in;
      end
   end

endmodule

// ----- design/a85_queue.sv -----
// Two-entry job queue between the front end and the character generator.
module a85_queue import a85_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type pop_job,
   output logic    empty,
   output logic    full
);

   job_type              mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff;
   logic [Q_PTR_W-1:0]   rd_ptr_ff;
   logic [Q_CNT_W-1:0]   count_ff, count_in;

   assign pop_job = mem_ff[rd_ptr_ff];
   assign empty   = (count_ff == '0);
   assign full    = (count_ff == Q_CNT_W'(Q_DEPTH));

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + Q_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + Q_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + Q_PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

// ----- design/a85_back.sv -----
// Back end: turns jobs into characters, one output beat per cycle while rsp_ready allows.
module a85_back import a85_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  job_type           q_job,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CHAR_W-1:0] rsp_out_char,
   output logic              rsp_last_char
);

   back_state_type       state_ff, state_in;
   job_type              job_ff;
   logic [FRAC_W-1:0]    frac_ff;
   logic [FRAC_W-1:0]    product;
   logic [FRAC_W+6:0]    scaled;
   logic [FRAC_W+6:0]    frac_wide;
   logic [NDIG_W-1:0]    dig_left_ff;
   logic                 out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]    out_char_ff, out_char_in;
   logic                 out_last_ff, out_last_in;
   logic                 adv;
   logic                 dig_step;

   function automatic back_state_type body_state(input job_type job);
      back_state_type st;
      if (job.kind == KIND_DIGITS) begin
         st = ST_DIGIT;
      end else if (job.kind == KIND_ZERO) begin
         st = ST_ZERO;
      end else if (job.close_req) begin
         st = ST_CLOSE1;
      end else begin
         st = ST_IDLE;
      end
      return st;
   endfunction

   function automatic back_state_type tail_state(input job_type job);
      return job.close_req ? ST_CLOSE1 : ST_IDLE;
   endfunction

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_char  = out_char_ff;
   assign rsp_last_char = out_last_ff;
   assign adv           = !out_valid_ff || rsp_ready;

   // Group scaled to a fraction of 85^5; the next digit is the integer part of frac * 85.
   assign product   = {{(FRAC_W-GROUP_W){1'b0}}, q_job.group}
                    * {{(FRAC_W-RECIP_W){1'b0}}, RECIP_85_5};
   assign frac_wide = {7'b0, frac_ff};
   assign scaled    = (frac_wide << 6) + (frac_wide << 4) + (frac_wide << 2) + frac_wide;

   always_comb begin
      state_in     = state_ff;
      q_pop        = 1'b0;
      dig_step     = 1'b0;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               state_in = q_job.open_req ? ST_OPEN1 : body_state(q_job);
            end
         end
         ST_OPEN1: begin
            if (adv) begin
               out_valid_in = 1'b1;
               out_char_in  = CHAR_LT;
               out_last_in  = 1'b0;
               state_in     = ST_OPEN2;
            end
         end
         ST_OPEN2: begin
            if (adv) begin
               out_valid_in = 1'b1;
               out_char_in  = CHAR_TILDE;
               out_last_in  = (body_state(job_ff) == ST_IDLE);
               state_in     = body_state(job_ff);
            end
         end
         ST_ZERO: begin
            if (adv) begin
               out_valid_in = 1'b1;
               out_char_in  = CHAR_Z;
               out_last_in  = !job_ff.close_req;
               state_in     = tail_state(job_ff);
            end
         end
         ST_DIGIT: begin
            if (adv) begin
               dig_step     = 1'b1;
               out_valid_in = 1'b1;
               out_char_in  = scaled[FRAC_W+6:FRAC_W] + DIGIT_OFFSET;
               out_last_in  = (dig_left_ff == 3'd1) && !job_ff.close_req;
               if (dig_left_ff == 3'd1) begin
                  state_in = tail_state(job_ff);
               end
            end
         end
         ST_CLOSE1: begin
            if (adv) begin
               out_valid_in = 1'b1;
               out_char_in  = CHAR_TILDE;
               out_last_in  = 1'b0;
               state_in     = ST_CLOSE2;
            end
         end
         ST_CLOSE2: begin
            if (adv) begin
               out_valid_in = 1'b1;
               out_char_in  = CHAR_GT;
               out_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
      if (q_pop) begin
         job_ff      <= q_job;
         frac_ff     <= product;
         dig_left_ff <= q_job.ndig;
      end else if (dig_step) begin
         frac_ff     <= scaled[FRAC_W-1:0];
         dig_left_ff <= dig_left_ff - 3'd1;
      end
   end

endmodule
